// ----- rtl/core/vertex_normal_smoothing_defines.svh -----
// Assertion macros for the vertex normal smoothing block.
// Used by rtl/core files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef VERTEX_NORMAL_SMOOTHING_DEFINES_SVH
`define VERTEX_NORMAL_SMOOTHING_DEFINES_SVH
`ifndef SYNTHESIS
`define VNS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define VNS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VNS_ASSERT_IMP(lbl, ante, cons, msg)
`define VNS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/vns_pkg.sv -----
// Package for vertex normal smoothing: sizes, command/status codes, sequencer states.
// No dependencies.
`default_nettype none
package vns_pkg;
  localparam int MAX_TRIANGLES = 1024;
  localparam int CORNER_SLOTS  = 3 * MAX_TRIANGLES;
  localparam int CA_W = $clog2(CORNER_SLOTS);
  localparam int NA_W = $clog2(MAX_TRIANGLES);

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_LOAD_POS = 2'd1;
  localparam logic [1:0] CMD_LOAD_NRM = 2'd2;
  localparam logic [1:0] CMD_QUERY    = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADIDX = 2'd1;
  localparam logic [1:0] STAT_ZERO   = 2'd2;

  localparam logic [16:0] UNIT_Q14 = 17'd16384;

  typedef enum logic [3:0] {
    S_IDLE, S_QDATA, S_SCAN, S_SQ, S_SHIFT, S_SQRT, S_DINIT, S_DIV, S_FIN
  } state_t;

  function automatic logic axis_close(input logic signed [31:0] a,
                                      input logic signed [31:0] b,
                                      input logic [30:0] tol);
    logic signed [32:0] d;
    logic [32:0] m;
    d = {a[31], a} - {b[31], b};
    m = d[32] ? 33'(-d) : 33'(d);
    return m <= {2'b00, tol};
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/vertex_normal_smoothing.sv -----
// Vertex normal smoothing: top level with corner/normal stores, scan and normalize sequencer.
// Depends on vns_pkg and vertex_normal_smoothing_defines.svh.
//
// Input stream in_*: tuser carries the command, tdata the values and vertex index.
// Clear and loads are taken while idle and give no result; a load beyond
// capacity is dropped. A query scans all T complete triangles, one corner per cycle
// through a single comparator, then runs a shared squarer, a radix-4 square root
// (32 steps) and a restoring divider per axis. An out-of-range index skips the
// scan and goes straight to the result. in_tready is low while a query runs.
// Result stream out_*: one transaction per query, held in an output register; a
// stalled receiver holds the result and, after a following query finishes, the
// sequencer waits for the register to empty. cfg_*: match tolerance, accepted
// every cycle; write it only while idle (the block does not enforce this).
// Reset (rst_n, synchronous) clears counts, tolerance and handshake state; the
// stores keep undefined contents and are never used before they are written.
`default_nettype none
`include "vertex_normal_smoothing_defines.svh"
module vertex_normal_smoothing
  import vns_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [111:0] in_tdata,   // value_x, value_y, value_z, vertex_index, pad
  input  wire logic [1:0]   in_tuser,   // command
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // normal_x, normal_y, normal_z, match_count, pad
  output logic [1:0]        out_tuser,  // status
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [30:0]  cfg_data
);
  state_t state_r, state_nxt;
  logic [30:0] tol_r;
  logic [CA_W-1:0] vcnt_r, vcnt_nxt;
  logic [NA_W:0] ncnt_r, ncnt_nxt, tris_r, tris_nxt;
  logic [1:0] lk_r, lk_nxt;

  logic [31:0] cx_mem [CORNER_SLOTS];
  logic [31:0] cy_mem [CORNER_SLOTS];
  logic [31:0] cz_mem [CORNER_SLOTS];
  logic [47:0] nrm_mem [MAX_TRIANGLES];
  logic cor_we, nrm_we;
  logic [CA_W-1:0] mem_ra;
  logic [NA_W-1:0] nrm_ra;
  logic signed [31:0] rx_r, ry_r, rz_r;
  logic [47:0] nrm_rd_r;

  logic signed [31:0] qx_r, qy_r, qz_r, qx_nxt, qy_nxt, qz_nxt;
  logic [CA_W-1:0] a_r, a_nxt;
  logic [1:0] k_r, k_nxt;
  logic [NA_W:0] t_r, t_nxt;
  logic p_vld_r, p_vld_nxt, p_last_r, p_last_nxt;
  logic [NA_W:0] p_tri_r, p_tri_nxt;
  logic hit_r, hit_nxt, match;
  logic [NA_W:0] cnt_r, cnt_nxt;
  logic signed [26:0] sx_r, sy_r, sz_r, sx_nxt, sy_nxt, sz_nxt;

  logic [1:0] j_r, j_nxt;
  logic signed [26:0] mul_op;
  logic signed [53:0] mul_full;
  logic [51:0] prod_r, prod_nxt;
  logic [63:0] x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt, rsum;
  logic [4:0] s_r, s_nxt;
  logic [31:0] len;
  logic [1:0] c_r, c_nxt;
  logic [4:0] b_r, b_nxt;
  logic [48:0] rem_r, rem_nxt, dsh;
  logic [16:0] quo_r, quo_nxt, qv;
  logic signed [26:0] comp;
  logic [26:0] mag;
  logic [47:0] num;
  logic [5:0] sh;
  logic [15:0] nx_r, ny_r, nz_r, nx_nxt, ny_nxt, nz_nxt, nres;
  logic [1:0] stat_r, stat_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [1:0] out_user_r, out_user_nxt;

  logic in_acc;
  logic [CA_W-1:0] qidx;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign in_acc     = in_tvalid & in_tready;
  assign qidx       = in_tdata[107:96];
  assign mul_full   = mul_op * mul_op;
  assign len        = (res_r[31:0] == 32'd0) ? 32'd1 : res_r[31:0];
  assign match      = axis_close(rx_r, qx_r, tol_r) & axis_close(ry_r, qy_r, tol_r) &
                      axis_close(rz_r, qz_r, tol_r);

  always_ff @(posedge clk) begin
    if (cor_we) begin
      cx_mem[vcnt_r] <= in_tdata[31:0];
      cy_mem[vcnt_r] <= in_tdata[63:32];
      cz_mem[vcnt_r] <= in_tdata[95:64];
    end
    if (nrm_we) begin
      nrm_mem[ncnt_r[NA_W-1:0]] <= {in_tdata[79:64], in_tdata[47:32], in_tdata[15:0]};
    end
    rx_r     <= cx_mem[mem_ra];
    ry_r     <= cy_mem[mem_ra];
    rz_r     <= cz_mem[mem_ra];
    nrm_rd_r <= nrm_mem[nrm_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tol_r        <= '0;
      vcnt_r       <= '0;
      ncnt_r       <= '0;
      tris_r       <= '0;
      lk_r         <= '0;
      p_vld_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_data;
      end
      vcnt_r       <= vcnt_nxt;
      ncnt_r       <= ncnt_nxt;
      tris_r       <= tris_nxt;
      lk_r         <= lk_nxt;
      p_vld_r      <= p_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qx_r <= qx_nxt; qy_r <= qy_nxt; qz_r <= qz_nxt;
    a_r <= a_nxt; k_r <= k_nxt; t_r <= t_nxt;
    p_last_r <= p_last_nxt; p_tri_r <= p_tri_nxt;
    hit_r <= hit_nxt; cnt_r <= cnt_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; sz_r <= sz_nxt;
    j_r <= j_nxt; prod_r <= prod_nxt; x_r <= x_nxt; s_r <= s_nxt;
    res_r <= res_nxt; bit_r <= bit_nxt;
    c_r <= c_nxt; b_r <= b_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
    nx_r <= nx_nxt; ny_r <= ny_nxt; nz_r <= nz_nxt; stat_r <= stat_nxt;
    out_data_r <= out_data_nxt; out_user_r <= out_user_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = (state_r == S_IDLE);
    vcnt_nxt = vcnt_r; ncnt_nxt = ncnt_r; tris_nxt = tris_r; lk_nxt = lk_r;
    cor_we = 1'b0; nrm_we = 1'b0;
    mem_ra = a_r; nrm_ra = t_r[NA_W-1:0];
    qx_nxt = qx_r; qy_nxt = qy_r; qz_nxt = qz_r;
    a_nxt = a_r; k_nxt = k_r; t_nxt = t_r;
    p_vld_nxt = 1'b0; p_last_nxt = p_last_r; p_tri_nxt = p_tri_r;
    hit_nxt = hit_r; cnt_nxt = cnt_r;
    sx_nxt = sx_r; sy_nxt = sy_r; sz_nxt = sz_r;
    j_nxt = j_r; prod_nxt = prod_r; x_nxt = x_r; s_nxt = s_r;
    res_nxt = res_r; bit_nxt = bit_r; rsum = res_r + bit_r;
    c_nxt = c_r; b_nxt = b_r; rem_nxt = rem_r; quo_nxt = quo_r;
    nx_nxt = nx_r; ny_nxt = ny_r; nz_nxt = nz_r; stat_nxt = stat_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_data_nxt = out_data_r; out_user_nxt = out_user_r;
    mul_op = sx_r;
    dsh = {16'd0, len, 1'b0} << b_r;
    qv = quo_r;
    nres = '0;
    case (c_r)
      2'd0:    comp = sx_r;
      2'd1:    comp = sy_r;
      default: comp = sz_r;
    endcase
    mag = comp[26] ? 27'(-comp) : 27'(comp);
    sh  = 6'd14 + {1'b0, s_r};
    num = {21'd0, mag} << sh;

    if (p_vld_r) begin
      hit_nxt = p_last_r ? 1'b0 : (hit_r | match);
      if (p_last_r && (hit_r || match)) begin
        cnt_nxt = cnt_r + 1'b1;
        if (p_tri_r < ncnt_r) begin
          sx_nxt = sx_r + 27'(signed'(nrm_rd_r[15:0]));
          sy_nxt = sy_r + 27'(signed'(nrm_rd_r[31:16]));
          sz_nxt = sz_r + 27'(signed'(nrm_rd_r[47:32]));
        end
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            CMD_CLEAR: begin
              vcnt_nxt = '0; ncnt_nxt = '0; tris_nxt = '0; lk_nxt = '0;
            end
            CMD_LOAD_POS: begin
              if (vcnt_r < CA_W'(CORNER_SLOTS)) begin
                cor_we = 1'b1;
                vcnt_nxt = vcnt_r + 1'b1;
                if (lk_r == 2'd2) begin
                  lk_nxt = '0;
                  tris_nxt = tris_r + 1'b1;
                end else begin
                  lk_nxt = lk_r + 1'b1;
                end
              end
            end
            CMD_LOAD_NRM: begin
              if (ncnt_r < (NA_W+1)'(MAX_TRIANGLES)) begin
                nrm_we = 1'b1;
                ncnt_nxt = ncnt_r + 1'b1;
              end
            end
            CMD_QUERY: begin
              cnt_nxt = '0; hit_nxt = 1'b0;
              sx_nxt = '0; sy_nxt = '0; sz_nxt = '0;
              a_nxt = '0; k_nxt = '0; t_nxt = '0;
              nx_nxt = '0; ny_nxt = '0; nz_nxt = '0;
              if (qidx >= vcnt_r) begin
                stat_nxt = STAT_BADIDX;
                state_nxt = S_FIN;
              end else begin
                mem_ra = qidx;
                state_nxt = S_QDATA;
              end
            end
            default: ;
          endcase
        end
      end
      S_QDATA: begin
        qx_nxt = rx_r; qy_nxt = ry_r; qz_nxt = rz_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (t_r != tris_r) begin
          p_vld_nxt = 1'b1;
          p_last_nxt = (k_r == 2'd2);
          p_tri_nxt = t_r;
          a_nxt = a_r + 1'b1;
          if (k_r == 2'd2) begin
            k_nxt = '0;
            t_nxt = t_r + 1'b1;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else if (!p_vld_r) begin
          j_nxt = '0;
          x_nxt = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        case (j_r)
          2'd0:    mul_op = sx_r;
          2'd1:    mul_op = sy_r;
          default: mul_op = sz_r;
        endcase
        if (j_r != 2'd0) begin
          x_nxt = x_r + {12'd0, prod_r};
        end
        prod_nxt = mul_full[51:0];
        j_nxt = j_r + 1'b1;
        if (j_r == 2'd3) begin
          s_nxt = '0;
          if (x_nxt == 64'd0) begin
            stat_nxt = STAT_ZERO;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (s_r < 5'd24 && x_r[63:60] == 4'd0) begin
          x_nxt = x_r << 2;
          s_nxt = s_r + 1'b1;
        end else begin
          res_nxt = '0;
          bit_nxt = 64'd1 << 62;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (bit_r != 64'd0) begin
          if (x_r >= rsum) begin
            x_nxt = x_r - rsum;
            res_nxt = (res_r >> 1) + bit_r;
          end else begin
            res_nxt = res_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end else begin
          c_nxt = '0;
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        rem_nxt = {num, 1'b0} + {17'd0, len};
        quo_nxt = '0;
        b_nxt = 5'd16;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (rem_r >= dsh) begin
          rem_nxt = rem_r - dsh;
          qv[b_r] = 1'b1;
        end
        quo_nxt = qv;
        if (b_r == 5'd0) begin
          if (qv > UNIT_Q14) begin
            qv = UNIT_Q14;
          end
          nres = comp[26] ? 16'(-qv[15:0]) : qv[15:0];
          case (c_r)
            2'd0:    nx_nxt = nres;
            2'd1:    ny_nxt = nres;
            default: nz_nxt = nres;
          endcase
          if (c_r == 2'd2) begin
            stat_nxt = STAT_OK;
            state_nxt = S_FIN;
          end else begin
            c_nxt = c_r + 1'b1;
            state_nxt = S_DINIT;
          end
        end else begin
          b_nxt = b_r - 1'b1;
        end
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt = {5'd0, cnt_r, nz_r, ny_r, nx_r};
          out_user_nxt = stat_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `VNS_ASSERT_IMP(a_cnt_le_tri, state_r == S_SCAN, cnt_r <= t_r, "match count ahead of scan")
  `VNS_ASSERT_IMP(a_shift_cap, state_r == S_SQRT, s_r <= 5'd24, "normalize shift overrun")
  `VNS_ASSERT_NXT(a_vload, in_acc && in_tuser == CMD_LOAD_POS &&
                  vcnt_r < CA_W'(CORNER_SLOTS), vcnt_r == $past(vcnt_r) + 1'b1,
                  "vertex load not counted")
endmodule
`default_nettype wire
